FILE: hw/rtl/ghx_pkg.sv
// ----------------------------------------------------------------------------
// ghx_pkg
// Shared types and constants for the gzip header name/comment extractor.
// ----------------------------------------------------------------------------
package ghx_pkg;

    localparam logic [7:0] MAGIC_FIRST    = 8'h1f;
    localparam logic [7:0] MAGIC_SECOND   = 8'h8b;
    localparam int         FLAG_FEXTRA    = 2;
    localparam int         FLAG_FNAME     = 3;
    localparam int         FLAG_FCOMMENT  = 4;
    localparam logic [3:0] POS_MAGIC_LOW  = 4'd0;
    localparam logic [3:0] POS_MAGIC_HIGH = 4'd1;
    localparam logic [3:0] POS_FLAGS      = 4'd3;
    localparam logic [3:0] POS_LAST_FIXED = 4'd9;
    localparam logic [3:0] POS_XLEN_LOW   = 4'd10;
    localparam logic [3:0] POS_XLEN_HIGH  = 4'd11;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_NAME,
        PH_COMMENT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_COMMENT = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_NO_NAME   = 3'd2,
        ST_NOT_ASCII = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_value;
        logic       end_of_field;
        status_t    status;
        logic       comment_follows;
    } result_t;

endpackage

FILE: hw/rtl/gzip_header_name_comment_extractor.sv
// a result is registered into the result queue when its byte is taken and is offered from the queue head
// throughput: one byte per cycle; input stalls only when the result queue
// holds QueueDepth entries
// reset (rst_n, asynchronous): parse idle until a first-byte mark, queue empty
// ----------------------------------------------------------------------------
// gzip_header_name_comment_extractor
// Walks a gzip header byte stream and emits file name and comment characters
// with a status on the last character of each field, or a status-only result when the header is bad or cut short.
// ----------------------------------------------------------------------------
module gzip_header_name_comment_extractor
    import ghx_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] char_value,
    output logic       end_of_field,
    output logic [2:0] status,
    output logic       comment_follows
);

    logic    take;
    logic    push;
    logic    full;
    result_t res;
    result_t head;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    ghx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .push       (push),
        .res        (res)
    );

    ghx_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (res),
        .full       (full),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head       (head)
    );

    assign result_kind     = head.kind;
    assign char_value      = head.char_value;
    assign end_of_field    = head.end_of_field;
    assign status          = head.status;
    assign comment_follows = head.comment_follows;

endmodule

FILE: hw/rtl/ghx_front.sv
// ----------------------------------------------------------------------------
// ghx_front
// Header walker: takes one byte per transfer, updates the parse state and
// produces at most one result per byte for the queue.
// ----------------------------------------------------------------------------
module ghx_front
    import ghx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       push,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  xlow_reg, xlow_next;
    logic [15:0] skip_reg, skip_next;
    logic        saw_reg, saw_next;

    // a first-byte mark restarts the parse at offset 0 with cleared state
    phase_t      cur_phase;
    logic [3:0]  cur_pos;
    logic [7:0]  cur_flags;
    logic [7:0]  cur_xlow;
    logic [15:0] cur_skip;
    logic        cur_saw;

    assign cur_phase = first_byte ? PH_HEADER : phase_reg;
    assign cur_pos   = first_byte ? 4'd0  : pos_reg;
    assign cur_flags = first_byte ? 8'd0  : flags_reg;
    assign cur_xlow  = first_byte ? 8'd0  : xlow_reg;
    assign cur_skip  = first_byte ? 16'd0 : skip_reg;
    assign cur_saw   = first_byte ? 1'b0  : saw_reg;

    logic        bad_magic;
    logic        no_name;
    logic [15:0] xlen;
    logic [15:0] skip_dec;
    logic        name_ok_end;
    logic        follows;

    assign bad_magic = (cur_pos == POS_MAGIC_LOW  && data_byte != MAGIC_FIRST) ||
                       (cur_pos == POS_MAGIC_HIGH && data_byte != MAGIC_SECOND);
    assign no_name   = (cur_pos == POS_FLAGS) && !data_byte[FLAG_FNAME];
    assign xlen      = {data_byte, cur_xlow};
    assign skip_dec  = cur_skip - 16'd1;
    assign name_ok_end = (cur_phase == PH_NAME) && !cur_saw;
    assign follows   = name_ok_end && cur_flags[FLAG_FCOMMENT] && !last_byte;

    // next parse phase
    always_comb
    begin
        phase_next = cur_phase;
        case (cur_phase)
            PH_HEADER:
            begin
                if (bad_magic || no_name)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (cur_pos == POS_XLEN_HIGH)
                    begin
                        phase_next = (xlen != 16'd0) ? PH_SKIP : PH_NAME;
                    end
                    else if (cur_pos == POS_LAST_FIXED && !cur_flags[FLAG_FEXTRA])
                    begin
                        phase_next = PH_NAME;
                    end
                    if (last_byte)
                    begin
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_SKIP:
            begin
                if (last_byte)
                begin
                    phase_next = PH_DONE;
                end
                else if (skip_dec == 16'd0)
                begin
                    phase_next = PH_NAME;
                end
            end
            PH_NAME, PH_COMMENT:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next = follows ? PH_COMMENT : PH_DONE;
                end
                else if (last_byte)
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    // datapath state and result
    always_comb
    begin
        pos_next   = cur_pos;
        flags_next = cur_flags;
        xlow_next  = cur_xlow;
        skip_next  = cur_skip;
        saw_next   = cur_saw;
        push       = 1'b0;
        res.kind            = KIND_STATUS;
        res.char_value      = 8'd0;
        res.end_of_field    = 1'b1;
        res.status          = ST_OK;
        res.comment_follows = 1'b0;
        case (cur_phase)
            PH_HEADER:
            begin
                pos_next = cur_pos + 4'd1;
                if (cur_pos == POS_FLAGS)
                begin
                    flags_next = data_byte;
                end
                if (cur_pos == POS_XLEN_LOW)
                begin
                    xlow_next = data_byte;
                end
                if (cur_pos == POS_XLEN_HIGH)
                begin
                    skip_next = xlen;
                end
                if (bad_magic)
                begin
                    push       = 1'b1;
                    res.status = ST_BAD_MAGIC;
                end
                else if (no_name)
                begin
                    push       = 1'b1;
                    res.status = ST_NO_NAME;
                end
                else if (last_byte)
                begin
                    push       = 1'b1;
                    res.status = ST_TRUNCATED;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (last_byte)
                begin
                    push       = 1'b1;
                    res.status = ST_TRUNCATED;
                end
            end
            PH_NAME, PH_COMMENT:
            begin
                push           = 1'b1;
                res.kind       = (cur_phase == PH_NAME) ? KIND_NAME : KIND_COMMENT;
                res.char_value = data_byte;
                if (data_byte == 8'd0)
                begin
                    saw_next            = 1'b0;
                    res.status          = cur_saw ? ST_NOT_ASCII : ST_OK;
                    res.comment_follows = follows;
                end
                else
                begin
                    saw_next = cur_saw | data_byte[7];
                    if (last_byte)
                    begin
                        res.status = ST_TRUNCATED;
                    end
                    else
                    begin
                        res.end_of_field = 1'b0;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
        push = push & take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 4'd0;
            flags_reg <= 8'd0;
            xlow_reg  <= 8'd0;
            skip_reg  <= 16'd0;
            saw_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            xlow_reg  <= xlow_next;
            skip_reg  <= skip_next;
            saw_reg   <= saw_next;
        end
    end

endmodule

FILE: hw/rtl/ghx_queue.sv
// ----------------------------------------------------------------------------
// ghx_queue
// Short result queue between the header walker and the output channel.
// ----------------------------------------------------------------------------
module ghx_queue
    import ghx_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    head_valid,
    input  logic    pop,
    output result_t head
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

    result_t       entry_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
